>>> hdl/tfs_pkg.sv
// tfs_pkg: shared types and constants of the timed fire sequencer
package tfs_pkg;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned DELTA_W = 8;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [MS_W-1:0] MS_MAX = '1;

	localparam logic [MS_W-1:0]   FIRE_DURATION_RST = 16'd3000;
	localparam logic [MS_W-1:0]   END_CUE_RST       = 16'd1000;
	localparam logic [MS_W-1:0]   COOLDOWN_RST      = 16'd10000;
	localparam logic [MODE_W-1:0] FIRE_MODE_RST     = 3'd0;

	typedef enum logic [CMD_W-1:0] {
		CMD_STEP      = 3'd0,
		CMD_END_FIRE  = 3'd1,
		CMD_SKIP_LOCK = 3'd2,
		CMD_RESET     = 3'd3,
		CMD_DRAIN     = 3'd4,
		CMD_PURGE_ON  = 3'd5,
		CMD_PURGE_OFF = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_FIRE = 2'd1,
		PH_CUE  = 2'd2,
		PH_COOL = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRE_MODE     = 2'd0,
		CFG_FIRE_DURATION = 2'd1,
		CFG_END_CUE       = 2'd2,
		CFG_COOLDOWN      = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic               press_event;
		logic               release_event;
		logic [DELTA_W-1:0] delta_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       fire_frame;
		logic       purge_on;
	} out_item_t;

	typedef struct packed {
		logic [MODE_W-1:0] fire_mode;
		logic [MS_W-1:0]   fire_duration_ms;
		logic [MS_W-1:0]   end_cue_ms;
		logic [MS_W-1:0]   cooldown_ms;
	} cfg_t;

	typedef struct packed {
		phase_t          phase;
		logic [MS_W-1:0] elapsed_ms;
		logic            fire_owed;
		logic            purge_flag;
	} seq_state_t;

endpackage

>>> hdl/tfs_step.sv
// tfs_step: next-state and result logic for one request
module tfs_step (
	input  tfs_pkg::seq_state_t cur,
	input  tfs_pkg::cfg_t       cfg,
	input  tfs_pkg::in_item_t   item,
	output tfs_pkg::seq_state_t nxt,
	output tfs_pkg::out_item_t  res
);

	logic [tfs_pkg::MS_W:0]   sum_ms;
	logic [tfs_pkg::MS_W-1:0] sat_ms;
	tfs_pkg::phase_t          after_fire;
	logic                     fire_frame;

	assign sum_ms = {1'b0, cur.elapsed_ms} + {{(tfs_pkg::MS_W+1-tfs_pkg::DELTA_W){1'b0}},
		item.delta_ms};
	assign sat_ms = sum_ms[tfs_pkg::MS_W] ? tfs_pkg::MS_MAX : sum_ms[tfs_pkg::MS_W-1:0];
	assign after_fire = (cfg.end_cue_ms == '0) ? tfs_pkg::PH_COOL : tfs_pkg::PH_CUE;

	always_comb begin
		nxt        = cur;
		fire_frame = 1'b0;
		case (item.cmd)
			tfs_pkg::CMD_STEP: begin
				nxt.elapsed_ms = sat_ms;
				case (cur.phase)
					tfs_pkg::PH_IDLE: begin
						if (item.press_event) begin
							nxt.phase      = tfs_pkg::PH_FIRE;
							nxt.elapsed_ms = '0;
							nxt.fire_owed  = 1'b1;
						end
					end
					tfs_pkg::PH_FIRE: begin
						if (sat_ms >= cfg.fire_duration_ms ||
							(cfg.fire_mode != '0 && item.release_event)) begin
							nxt.phase      = after_fire;
							nxt.elapsed_ms = '0;
						end
					end
					tfs_pkg::PH_CUE: begin
						if (sat_ms >= cfg.end_cue_ms) begin
							nxt.phase      = tfs_pkg::PH_COOL;
							nxt.elapsed_ms = '0;
						end
					end
					default: begin
						if (sat_ms >= cfg.cooldown_ms) begin
							nxt.phase      = tfs_pkg::PH_IDLE;
							nxt.elapsed_ms = '0;
						end
					end
				endcase
			end
			tfs_pkg::CMD_END_FIRE: begin
				if (cur.phase == tfs_pkg::PH_FIRE) begin
					nxt.phase      = after_fire;
					nxt.elapsed_ms = '0;
				end
			end
			tfs_pkg::CMD_SKIP_LOCK: begin
				if (cur.phase == tfs_pkg::PH_CUE || cur.phase == tfs_pkg::PH_COOL) begin
					nxt.phase      = tfs_pkg::PH_IDLE;
					nxt.elapsed_ms = '0;
				end
			end
			tfs_pkg::CMD_RESET: begin
				nxt.phase      = tfs_pkg::PH_IDLE;
				nxt.elapsed_ms = '0;
				nxt.fire_owed  = 1'b0;
			end
			tfs_pkg::CMD_DRAIN: begin
				fire_frame    = cur.fire_owed;
				nxt.fire_owed = 1'b0;
			end
			tfs_pkg::CMD_PURGE_ON:  nxt.purge_flag = 1'b1;
			tfs_pkg::CMD_PURGE_OFF: nxt.purge_flag = 1'b0;
			default: ;
		endcase
	end

	always_comb begin
		res.phase      = nxt.phase;
		res.fire_frame = fire_frame;
		res.purge_on   = nxt.purge_flag;
	end

endmodule

>>> hdl/timed_fire_sequencer.sv
// timed_fire_sequencer: top level of the four-phase fire sequencer
//
// usage
//  - request channel: in_valid / in_stall / in_data (cmd, press and release
//    events, delta_ms); a request is taken on a rising edge with in_valid high
//    and in_stall low
//  - result channel: out_valid / out_stall / out_data (phase, fire_frame,
//    purge_on); exactly one result per request, in request order
//  - config channel: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
//    always high, write only while no request is in flight
//  - result: registered, the result sits in the output register the cycle
//    after its request is taken
//  - throughput: one request per cycle while in_stall is low; the state update is a single
//    saturating add and compare between the state registers and the output
//    register, so the phase state is ready for the next request at once
//  - stall: when the output register holds a result and out_stall is high,
//    in_stall rises and the request side waits; the held result stays put
//  - reset (arst_n low): phase idle, elapsed time, fire-owed latch and purge
//    cleared, registers back to 3000 / 1000 / 10000 ms and mode 0, no result
//    pending
module timed_fire_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  tfs_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output tfs_pkg::out_item_t                 out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tfs_pkg::MS_W-1:0]           cfg_data
);

	// configuration registers
	tfs_pkg::cfg_t       cfg_q;
	// sequencer state
	tfs_pkg::seq_state_t state_q;
	tfs_pkg::seq_state_t state_nxt;
	tfs_pkg::out_item_t  res;
	// output register
	logic                out_valid_q;
	tfs_pkg::out_item_t  out_data_q;
	logic                in_accept;

	// output register can take a new result unless it is full and stalled
	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	tfs_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (in_data),
		.nxt  (state_nxt),
		.res  (res)
	);

	// config writes, index beyond the list never occurs with a 2-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fire_mode        <= tfs_pkg::FIRE_MODE_RST;
			cfg_q.fire_duration_ms <= tfs_pkg::FIRE_DURATION_RST;
			cfg_q.end_cue_ms       <= tfs_pkg::END_CUE_RST;
			cfg_q.cooldown_ms      <= tfs_pkg::COOLDOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tfs_pkg::CFG_FIRE_MODE:
					cfg_q.fire_mode <= cfg_data[tfs_pkg::MODE_W-1:0];
				tfs_pkg::CFG_FIRE_DURATION: cfg_q.fire_duration_ms <= cfg_data;
				tfs_pkg::CFG_END_CUE:       cfg_q.end_cue_ms       <= cfg_data;
				tfs_pkg::CFG_COOLDOWN:      cfg_q.cooldown_ms      <= cfg_data;
				default: ;
			endcase
		end
	end

	// state advances once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= tfs_pkg::PH_IDLE;
			state_q.elapsed_ms <= '0;
			state_q.fire_owed  <= 1'b0;
			state_q.purge_flag <= 1'b0;
		end else if (in_accept) begin
			state_q <= state_nxt;
		end
	end

	// result valid: set on accept, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> hdl/tfs_checker.sv
// tfs_checker: port-level assertions for the fire sequencer, bound to the top
module tfs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input tfs_pkg::in_item_t             in_data,
	input logic                          out_valid,
	input logic                          out_stall,
	input tfs_pkg::out_item_t            out_data,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [tfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tfs_pkg::MS_W-1:0]      cfg_data
);

	logic in_accept;
	assign in_accept = in_valid & ~in_stall;

	// a held result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// every accepted request yields a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid)
		else $error("accepted request without result");

	// no back-pressure while the output register is empty
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// fire_frame only answers a drain
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_data.cmd != tfs_pkg::CMD_DRAIN |=> !out_data.fire_frame)
		else $error("fire_frame outside drain");

	// reset command lands in idle
	a_reset_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_data.cmd == tfs_pkg::CMD_RESET |=>
		out_data.phase == tfs_pkg::PH_IDLE && !out_data.fire_frame)
		else $error("reset command did not go idle");

	logic unused_cfg;
	assign unused_cfg = cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data) ^ out_data.purge_on;

endmodule

bind timed_fire_sequencer tfs_checker u_tfs_checker (.*);

>>> tb/sv/timed_fire_sequencer_test.sv
// timed_fire_sequencer_test: self-checking testbench of the timed fire sequencer
module timed_fire_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tfs_pkg::*;

	// command code with no function, the block must leave its state alone
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	// cycles in a row without any handshake before the run is declared hung
	localparam int QUIET_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [MS_W-1:0]      cfg_data  = '0;

	// requests waiting for the driver, results waiting for the block
	in_item_t  req_queue[$];
	out_item_t expected_results[$];

	// shadow copy of the register file and of the sequencer state
	cfg_t       shadow_cfg;
	seq_state_t shadow_seq;

	int pushed_total    = 0;
	int results_checked = 0;
	int mismatch_cnt    = 0;
	int burst_left      = 1;
	int gap_left        = 0;
	int flow_left       = 0;
	int stall_left      = 0;
	int quiet_cycles    = 0;
	out_item_t oldest;

	timed_fire_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// sequencer prediction
	// ------------------------------------------------------------------

	// every phase entry restarts the millisecond count, entering firing owes a frame
	function automatic void enter_phase(phase_t next_phase);
		shadow_seq.phase      = next_phase;
		shadow_seq.elapsed_ms = '0;
		if (next_phase == PH_FIRE) begin
			shadow_seq.fire_owed = 1'b1;
		end
	endfunction

	// a zero end cue goes straight to the lockout
	function automatic phase_t after_fire_phase();
		if (shadow_cfg.end_cue_ms == '0) begin
			return PH_COOL;
		end
		return PH_CUE;
	endfunction

	function automatic out_item_t advance_sequencer(in_item_t req);
		logic [MS_W:0] sum;
		logic          frame;
		out_item_t     res;
		frame = 1'b0;
		case (req.cmd)
			CMD_STEP: begin
				// saturating millisecond count, then at most one transition
				sum = {1'b0, shadow_seq.elapsed_ms} + req.delta_ms;
				shadow_seq.elapsed_ms = (sum > MS_MAX) ? MS_MAX : sum[MS_W-1:0];
				case (shadow_seq.phase)
					PH_IDLE: begin
						if (req.press_event) begin
							enter_phase(PH_FIRE);
						end
					end
					PH_FIRE: begin
						if (shadow_seq.elapsed_ms >= shadow_cfg.fire_duration_ms ||
								(shadow_cfg.fire_mode != '0 && req.release_event)) begin
							enter_phase(after_fire_phase());
						end
					end
					PH_CUE: begin
						if (shadow_seq.elapsed_ms >= shadow_cfg.end_cue_ms) begin
							enter_phase(PH_COOL);
						end
					end
					default: begin
						if (shadow_seq.elapsed_ms >= shadow_cfg.cooldown_ms) begin
							enter_phase(PH_IDLE);
						end
					end
				endcase
			end
			CMD_END_FIRE: begin
				if (shadow_seq.phase == PH_FIRE) begin
					enter_phase(after_fire_phase());
				end
			end
			CMD_SKIP_LOCK: begin
				if (shadow_seq.phase == PH_CUE || shadow_seq.phase == PH_COOL) begin
					enter_phase(PH_IDLE);
				end
			end
			CMD_RESET: begin
				// purge and the registers survive a reset command
				shadow_seq.fire_owed = 1'b0;
				enter_phase(PH_IDLE);
			end
			CMD_DRAIN: begin
				frame                = shadow_seq.fire_owed;
				shadow_seq.fire_owed = 1'b0;
			end
			CMD_PURGE_ON: begin
				shadow_seq.purge_flag = 1'b1;
			end
			CMD_PURGE_OFF: begin
				shadow_seq.purge_flag = 1'b0;
			end
			default: begin
				// unused code, nothing changes
			end
		endcase
		res.phase      = shadow_seq.phase;
		res.fire_frame = frame;
		res.purge_on   = shadow_seq.purge_flag;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic void queue_req(logic [CMD_W-1:0] cmd, logic press, logic rel,
			logic [DELTA_W-1:0] delta);
		in_item_t r;
		r.cmd           = cmd;
		r.press_event   = press;
		r.release_event = rel;
		r.delta_ms      = delta;
		req_queue.push_back(r);
		pushed_total++;
	endfunction

	// every request pushed so far has had its result checked, block is idle
	task automatic wait_drained();
		do @(posedge clk);
		while (results_checked != pushed_total);
		// a margin on top, before the next step starts
		repeat (3) @(posedge clk);
	endtask

	// the shadow copy follows a register only once the write handshake is done
	task automatic write_register(cfg_idx_t idx, logic [MS_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FIRE_MODE:     shadow_cfg.fire_mode        = value[MODE_W-1:0];
			CFG_FIRE_DURATION: shadow_cfg.fire_duration_ms = value;
			CFG_END_CUE:       shadow_cfg.end_cue_ms       = value;
			default:           shadow_cfg.cooldown_ms      = value;
		endcase
	endtask

	// one setting of the registers followed by a run of random requests;
	// steps dominate so that the phases are walked through, other commands
	// and ignored fields come in as noise
	task automatic run_phase(logic [MS_W-1:0] mode_word, logic [MS_W-1:0] fire_ms,
			logic [MS_W-1:0] cue_ms, logic [MS_W-1:0] cool_ms, int count,
			int full_delta_pct, int other_cmd_pct);
		logic [CMD_W-1:0]   cmd;
		logic [DELTA_W-1:0] delta;
		write_register(CFG_FIRE_MODE, mode_word);
		write_register(CFG_FIRE_DURATION, fire_ms);
		write_register(CFG_END_CUE, cue_ms);
		write_register(CFG_COOLDOWN, cool_ms);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(1, 100) <= other_cmd_pct) begin
				cmd = 3'($urandom_range(1, 7));
			end else begin
				cmd = CMD_STEP;
			end
			if ($urandom_range(1, 100) <= full_delta_pct) begin
				delta = '1;
			end else if ($urandom_range(0, 3) == 0) begin
				delta = '0;
			end else begin
				delta = 8'($urandom_range(0, 255));
			end
			queue_req(cmd, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0), delta);
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// request driver: bursts of random length with random gaps between them
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_data    <= '0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			// request taken at this edge, predict its result
			if (in_valid && !in_stall) begin
				expected_results.push_back(advance_sequencer(in_data));
			end
			// a stalled request holds still
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					in_valid <= 1'b1;
					in_data  <= req_queue.pop_front();
					burst_left--;
					if (burst_left == 0) begin
						// some bursts follow each other with no gap at all
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor and receiver stall pattern
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			flow_left  = 0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("%0t: result with no request pending: phase=%0d frame=%0b purge=%0b",
							$realtime, out_data.phase, out_data.fire_frame, out_data.purge_on);
					end
				end else begin
					oldest = expected_results.pop_front();
					results_checked++;
					if (out_data.phase !== oldest.phase ||
							out_data.fire_frame !== oldest.fire_frame ||
							out_data.purge_on !== oldest.purge_on) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("%0t: result %0d mismatch: expected phase=%0d frame=%0b purge=%0b, got phase=%0d frame=%0b purge=%0b",
								$realtime, results_checked, oldest.phase, oldest.fire_frame,
								oldest.purge_on, out_data.phase, out_data.fire_frame,
								out_data.purge_on);
						end
					end
				end
			end
			// free-flowing stretch, then a stall stretch; now and then a long
			// stretch with no stall at all
			if (flow_left != 0) begin
				flow_left--;
				out_stall <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				flow_left  = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
					: $urandom_range(0, 12);
				stall_left = $urandom_range(1, 8);
				out_stall  <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: no handshake of any kind for too long means a hang
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		shadow_cfg.fire_mode        = FIRE_MODE_RST;
		shadow_cfg.fire_duration_ms = FIRE_DURATION_RST;
		shadow_cfg.end_cue_ms       = END_CUE_RST;
		shadow_cfg.cooldown_ms      = COOLDOWN_RST;
		shadow_seq.phase            = PH_IDLE;
		shadow_seq.elapsed_ms       = '0;
		shadow_seq.fire_owed        = 1'b0;
		shadow_seq.purge_flag       = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk under the reset register values
		queue_req(CMD_UNUSED, 1'b1, 1'b1, 8'd255);      // unused code, fields ignored
		queue_req(CMD_END_FIRE, 1'b0, 1'b0, 8'd0);      // end fire while idle
		queue_req(CMD_SKIP_LOCK, 1'b0, 1'b0, 8'd0);     // skip lockout while idle
		queue_req(CMD_DRAIN, 1'b0, 1'b0, 8'd0);         // nothing owed yet
		queue_req(CMD_PURGE_ON, 1'b0, 1'b0, 8'd0);
		queue_req(CMD_PURGE_OFF, 1'b0, 1'b0, 8'd0);
		queue_req(CMD_PURGE_ON, 1'b0, 1'b0, 8'd0);
		queue_req(CMD_STEP, 1'b0, 1'b1, 8'd0);          // release outside firing
		queue_req(CMD_STEP, 1'b1, 1'b0, 8'd255);        // press starts firing
		queue_req(CMD_STEP, 1'b1, 1'b1, 8'd0);          // mode 0 ignores release
		queue_req(CMD_DRAIN, 1'b0, 1'b0, 8'd0);         // owed frame comes out once
		queue_req(CMD_DRAIN, 1'b0, 1'b0, 8'd0);
		queue_req(CMD_END_FIRE, 1'b0, 1'b0, 8'd0);      // into end cue
		queue_req(CMD_STEP, 1'b1, 1'b0, 8'd255);        // press outside idle
		queue_req(CMD_SKIP_LOCK, 1'b0, 1'b0, 8'd0);     // end cue back to idle
		queue_req(CMD_STEP, 1'b1, 1'b0, 8'd1);
		queue_req(CMD_RESET, 1'b0, 1'b0, 8'd0);         // reset drops the owed frame
		queue_req(CMD_DRAIN, 1'b0, 1'b0, 8'd0);
		queue_req(CMD_STEP, 1'b1, 1'b0, 8'd0);
		queue_req(CMD_END_FIRE, 1'b0, 1'b0, 8'd0);
		repeat (4) queue_req(CMD_STEP, 1'b0, 1'b0, 8'd255);  // end cue runs out
		queue_req(CMD_END_FIRE, 1'b0, 1'b0, 8'd0);      // end fire during cooldown
		queue_req(CMD_SKIP_LOCK, 1'b0, 1'b0, 8'd0);     // skip the lockout
		queue_req(CMD_PURGE_OFF, 1'b0, 1'b0, 8'd0);
		wait_drained();

		// all times zero: firing ends on the next step, end cue skipped
		run_phase(16'h0000, 16'd0, 16'd0, 16'd0, 100, 10, 25);
		// all times at the top, mode 0 with upper data bits set: the count saturates
		run_phase(16'hFFF8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 500, 90, 0);
		// mode 6, release stops firing, no end cue
		run_phase(16'hFFFE, 16'd200, 16'd0, 16'd300, 150, 20, 20);
		// random settings
		repeat (2) begin
			run_phase({13'($urandom_range(0, 8191)), 3'($urandom_range(0, 6))},
				16'($urandom_range(0, 1500)), 16'($urandom_range(0, 800)),
				16'($urandom_range(0, 1500)), 120, 20, 20);
		end
		// one millisecond everywhere
		run_phase(16'h0001, 16'd1, 16'd1, 16'd1, 100, 5, 20);
		// back to the reset values
		run_phase({13'd0, FIRE_MODE_RST}, FIRE_DURATION_RST, END_CUE_RST, COOLDOWN_RST,
			150, 50, 15);

		if (mismatch_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
